@@ hdl/rrx_pkg.sv @@
// shared types and constants for the receive ring with xon/xoff flow control
package rrx_pkg;

    localparam int DATA_W  = 8;
    localparam int LEVEL_W = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [DATA_W-1:0] CHAR_XOFF = 8'h13;
    localparam logic [DATA_W-1:0] CHAR_XON  = 8'h11;

    localparam logic [LEVEL_W-1:0] HIGH_LEVEL_RST = 13'd3969;
    localparam logic [LEVEL_W-1:0] LOW_LEVEL_RST  = 13'd127;

    typedef enum logic [1:0] {
        OP_RECEIVE = 2'd0,
        OP_READ    = 2'd1,
        OP_FLUSH   = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FLOW_ENABLE = 2'd0,
        CFG_HIGH_LEVEL  = 2'd1,
        CFG_LOW_LEVEL   = 2'd2
    } cfg_idx_t;

    // memory strobes from control to ring storage
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

    // per-transaction result fields, read byte comes from the ring storage
    typedef struct packed {
        logic               read_valid;
        logic               send_flow;
        logic [DATA_W-1:0]  flow_char;
        logic               overflow;
        logic [LEVEL_W-1:0] fill_count;
    } res_t;

endpackage

@@ hdl/rx_ring_with_xon_xoff.sv @@
// top level of the receive byte ring with xon/xoff flow control
//
//  channel   signals                                     direction
//  in        in_valid, in_ready, op, rx_byte             transaction in
//  out       out_valid, out_ready, read_valid, read_byte,
//            send_flow, flow_char, overflow, fill_count  one result per transaction
//  cfg       cfg_we, cfg_index, cfg_data                 register write, no wait
//
// one transaction per cycle while in_ready is high; the result appears in the cycle after acceptance
// the output register lines up with the registered read port of the ring storage
// in_ready drops only while a result sits in the output register and out_ready is low
// reset clears pointers, fill count and pending xoff; storage is not cleared,
// bytes are only read after being written
module rx_ring_with_xon_xoff #(
    parameter int BUF_DEPTH = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_we,
    input  logic [rrx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rrx_pkg::LEVEL_W-1:0]   cfg_data,
    // input transaction
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    op,
    input  logic [rrx_pkg::DATA_W-1:0]    rx_byte,
    // result transaction
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          read_valid,
    output logic [rrx_pkg::DATA_W-1:0]    read_byte,
    output logic                          send_flow,
    output logic [rrx_pkg::DATA_W-1:0]    flow_char,
    output logic                          overflow,
    output logic [rrx_pkg::LEVEL_W-1:0]   fill_count
);

    // pointer and count widths follow the ring depth
    localparam int AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int CNT_W = $clog2(BUF_DEPTH + 1);

    logic                       accept;
    rrx_pkg::mem_ctl_t          mem_ctl;
    logic [AW-1:0]              waddr;
    logic [AW-1:0]              raddr;
    logic [rrx_pkg::DATA_W-1:0] rdata;
    rrx_pkg::res_t              res;

    // output register state
    logic          out_valid_reg;
    rrx_pkg::res_t res_reg;

    // accept whenever the output register is empty or being drained
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    rrx_ctrl #(
        .BUF_DEPTH (BUF_DEPTH),
        .AW        (AW),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .op        (op),
        .mem_ctl   (mem_ctl),
        .waddr     (waddr),
        .raddr     (raddr),
        .res       (res)
    );

    rrx_mem #(
        .DEPTH (BUF_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .ctl   (mem_ctl),
        .waddr (waddr),
        .wdata (rx_byte),
        .raddr (raddr),
        .rdata (rdata)
    );

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    // result payload, loaded together with the storage read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_valid = res_reg.read_valid;
    // byte reads as zero unless this transaction returned one
    assign read_byte  = res_reg.read_valid ? rdata : '0;
    assign send_flow  = res_reg.send_flow;
    assign flow_char  = res_reg.flow_char;
    assign overflow   = res_reg.overflow;
    assign fill_count = res_reg.fill_count;

endmodule

@@ hdl/rrx_mem.sv @@
// ring byte storage, one write port and one registered read port
module rrx_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                     clk,
    input  rrx_pkg::mem_ctl_t        ctl,
    input  logic [AW-1:0]            waddr,
    input  logic [rrx_pkg::DATA_W-1:0] wdata,
    input  logic [AW-1:0]            raddr,
    output logic [rrx_pkg::DATA_W-1:0] rdata
);

    logic [rrx_pkg::DATA_W-1:0] mem [DEPTH];
    logic [rrx_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read so a stalled result keeps its byte
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/rrx_ctrl.sv @@
// ring pointers, fill count, flow control state and configuration registers
module rrx_ctrl #(
    parameter int BUF_DEPTH = 4096,
    parameter int AW        = 12,
    parameter int CNT_W     = 13
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rrx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rrx_pkg::LEVEL_W-1:0]   cfg_data,
    input  logic                          accept,
    input  logic [1:0]                    op,
    output rrx_pkg::mem_ctl_t             mem_ctl,
    output logic [AW-1:0]                 waddr,
    output logic [AW-1:0]                 raddr,
    output rrx_pkg::res_t                 res
);

    localparam int CMP_W = (CNT_W > rrx_pkg::LEVEL_W) ? CNT_W : rrx_pkg::LEVEL_W;
    localparam logic [AW-1:0]    LAST_POS = AW'(BUF_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(BUF_DEPTH);

    logic                        flow_en_reg;
    logic [rrx_pkg::LEVEL_W-1:0] high_reg;
    logic [rrx_pkg::LEVEL_W-1:0] low_reg;

    logic [AW-1:0]    wr_pos_reg, wr_pos_next;
    logic [AW-1:0]    rd_pos_reg, rd_pos_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             xoff_reg, xoff_next;
    rrx_pkg::mem_ctl_t ctl;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flow_en_reg <= 1'b0;
            high_reg    <= rrx_pkg::HIGH_LEVEL_RST;
            low_reg     <= rrx_pkg::LOW_LEVEL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rrx_pkg::CFG_FLOW_ENABLE: flow_en_reg <= cfg_data[0];
                rrx_pkg::CFG_HIGH_LEVEL:  high_reg    <= cfg_data;
                rrx_pkg::CFG_LOW_LEVEL:   low_reg     <= cfg_data;
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        wr_pos_next = wr_pos_reg;
        rd_pos_next = rd_pos_reg;
        cnt_next    = cnt_reg;
        xoff_next   = xoff_reg;
        ctl         = '0;
        res         = '0;
        case (op)
            rrx_pkg::OP_RECEIVE:
            begin
                if (cnt_reg == FULL_CNT)
                begin
                    res.overflow = 1'b1;
                end
                else
                begin
                    ctl.wr_en   = 1'b1;
                    wr_pos_next = (wr_pos_reg == LAST_POS) ? '0 : wr_pos_reg + 1'b1;
                    cnt_next    = cnt_reg + 1'b1;
                end
                // xoff check uses the fill after the store
                if (flow_en_reg && !xoff_reg &&
                    (CMP_W'(cnt_next) > CMP_W'(high_reg)))
                begin
                    xoff_next     = 1'b1;
                    res.send_flow = 1'b1;
                    res.flow_char = rrx_pkg::CHAR_XOFF;
                end
            end
            rrx_pkg::OP_READ:
            begin
                // xon check uses the fill before the read
                if (xoff_reg && (CMP_W'(cnt_reg) < CMP_W'(low_reg)))
                begin
                    xoff_next     = 1'b0;
                    res.send_flow = 1'b1;
                    res.flow_char = rrx_pkg::CHAR_XON;
                end
                if (cnt_reg != '0)
                begin
                    ctl.rd_en      = 1'b1;
                    res.read_valid = 1'b1;
                    rd_pos_next    = (rd_pos_reg == LAST_POS) ? '0 : rd_pos_reg + 1'b1;
                    cnt_next       = cnt_reg - 1'b1;
                end
            end
            rrx_pkg::OP_FLUSH:
            begin
                if (xoff_reg)
                begin
                    xoff_next     = 1'b0;
                    res.send_flow = 1'b1;
                    res.flow_char = rrx_pkg::CHAR_XON;
                end
                wr_pos_next = '0;
                rd_pos_next = '0;
                cnt_next    = '0;
            end
            default:
            begin
            end
        endcase
        res.fill_count = rrx_pkg::LEVEL_W'(cnt_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_pos_reg <= '0;
            rd_pos_reg <= '0;
            cnt_reg    <= '0;
            xoff_reg   <= 1'b0;
        end
        else if (accept)
        begin
            wr_pos_reg <= wr_pos_next;
            rd_pos_reg <= rd_pos_next;
            cnt_reg    <= cnt_next;
            xoff_reg   <= xoff_next;
        end
    end

    assign mem_ctl.wr_en = ctl.wr_en & accept;
    assign mem_ctl.rd_en = ctl.rd_en & accept;
    assign waddr = wr_pos_reg;
    assign raddr = rd_pos_reg;

endmodule

@@ hdl/rrx_checker.sv @@
// port level checks for the receive ring, bound to the top level
module rrx_checker #(
    parameter int BUF_DEPTH = 4096
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          read_valid,
    input logic [rrx_pkg::DATA_W-1:0]    read_byte,
    input logic                          send_flow,
    input logic [rrx_pkg::DATA_W-1:0]    flow_char,
    input logic                          overflow,
    input logic [rrx_pkg::LEVEL_W-1:0]   fill_count
);

    localparam bit CNT_FITS = (BUF_DEPTH < (1 << rrx_pkg::LEVEL_W));

    // a stalled result holds its fields
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_byte) &&
        $stable(flow_char) && $stable(fill_count))
        else $error("result changed while stalled");

    // a transaction either reads or drops a byte, never both
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(read_valid && overflow))
        else $error("read and overflow in one result");

    // flow character is xon or xoff when sent, zero otherwise
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (send_flow && (flow_char == rrx_pkg::CHAR_XOFF ||
        flow_char == rrx_pkg::CHAR_XON)) || (!send_flow && flow_char == '0))
        else $error("bad flow character");

    // fill never exceeds depth
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !CNT_FITS || (int'(fill_count) <= BUF_DEPTH))
        else $error("fill count above depth");

    // empty read returns a zero byte; every accepted transaction yields a result
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid && (read_valid || read_byte == '0))
        else $error("missing result or nonzero empty byte");

endmodule

bind rx_ring_with_xon_xoff rrx_checker #(
    .BUF_DEPTH (BUF_DEPTH)
) u_rrx_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_valid (read_valid),
    .read_byte  (read_byte),
    .send_flow  (send_flow),
    .flow_char  (flow_char),
    .overflow   (overflow),
    .fill_count (fill_count)
);

@@ sim/rx_ring_with_xon_xoff_test.sv @@
// testbench for the receive ring with xon/xoff: directed, random and back-pressure runs
`timescale 1ns / 1ps

module rx_ring_with_xon_xoff_test;

    // ring size of the block as instantiated (default parameter)
    localparam int RING_DEPTH = 4096;

    // op code with no operation behind it, and the register index that selects nothing
    localparam logic [1:0]                    OP_NOP     = 2'd3;
    localparam logic [rrx_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // one result transaction as the ring should return it
    typedef struct packed {
        logic                        read_valid;
        logic [rrx_pkg::DATA_W-1:0]  read_byte;
        logic                        send_flow;
        logic [rrx_pkg::DATA_W-1:0]  flow_char;
        logic                        overflow;
        logic [rrx_pkg::LEVEL_W-1:0] fill_count;
    } ring_result_t;

    // clock, reset and block ports
    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          cfg_we    = 1'b0;
    logic [rrx_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [rrx_pkg::LEVEL_W-1:0]   cfg_data  = '0;
    logic                          in_valid  = 1'b0;
    logic                          in_ready;
    logic [1:0]                    op        = rrx_pkg::OP_RECEIVE;
    logic [rrx_pkg::DATA_W-1:0]    rx_byte   = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic                          read_valid;
    logic [rrx_pkg::DATA_W-1:0]    read_byte;
    logic                          send_flow;
    logic [rrx_pkg::DATA_W-1:0]    flow_char;
    logic                          overflow;
    logic [rrx_pkg::LEVEL_W-1:0]   fill_count;

    // predicted ring contents, pointers and flow state
    logic [rrx_pkg::DATA_W-1:0]  ring_mem [RING_DEPTH];
    int                          wr_ptr    = 0;
    int                          rd_ptr    = 0;
    int                          held      = 0;
    logic                        xoff_pend = 1'b0;

    // predicted register values, reset defaults
    logic                        flow_on    = 1'b0;
    logic [rrx_pkg::LEVEL_W-1:0] high_mark  = rrx_pkg::HIGH_LEVEL_RST;
    logic [rrx_pkg::LEVEL_W-1:0] low_mark   = rrx_pkg::LOW_LEVEL_RST;

    // results still owed by the block, oldest first
    ring_result_t pending_results [$];

    // idle pacing of both sides, in percent of cycles
    int send_idle_pct  = 30;
    int recv_stall_pct = 82;
    // long receiver hold-off request, picked up by the result sink
    int hold_request   = 0;

    // tallies for the closing summary
    int err_count   = 0;
    int n_items     = 0;
    int n_stores    = 0;
    int n_bytes_out = 0;
    int n_empty     = 0;
    int n_flushes   = 0;
    int n_nops      = 0;
    int n_xoff      = 0;
    int n_xon       = 0;
    int n_dropped   = 0;
    int n_reg_wr    = 0;

    rx_ring_with_xon_xoff dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_valid (read_valid),
        .read_byte  (read_byte),
        .send_flow  (send_flow),
        .flow_char  (flow_char),
        .overflow   (overflow),
        .fill_count (fill_count)
    );

    always #10 clk = ~clk;

    // hard stop in case the block hangs
    initial
    begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // ring predictor: applies one transaction to the local copy of the
    // state and returns the result the block must produce for it
    // ------------------------------------------------------------------
    function automatic ring_result_t ring_next_result(
        input logic [1:0]               op_code,
        input logic [rrx_pkg::DATA_W-1:0] data
    );
        ring_result_t r;
        r = '0;
        case (op_code)
            rrx_pkg::OP_RECEIVE:
            begin
                // full ring drops the byte, xoff check still runs on the old fill
                if (held >= RING_DEPTH)
                    r.overflow = 1'b1;
                else
                begin
                    ring_mem[wr_ptr] = data;
                    wr_ptr = (wr_ptr + 1) % RING_DEPTH;
                    held++;
                end
                if (flow_on && held > int'(high_mark) && !xoff_pend)
                begin
                    xoff_pend   = 1'b1;
                    r.send_flow = 1'b1;
                    r.flow_char = rrx_pkg::CHAR_XOFF;
                end
            end
            rrx_pkg::OP_READ:
            begin
                // xon release is decided on the fill before the byte leaves
                if (held < int'(low_mark) && xoff_pend)
                begin
                    xoff_pend   = 1'b0;
                    r.send_flow = 1'b1;
                    r.flow_char = rrx_pkg::CHAR_XON;
                end
                if (held != 0)
                begin
                    r.read_valid = 1'b1;
                    r.read_byte  = ring_mem[rd_ptr];
                    rd_ptr = (rd_ptr + 1) % RING_DEPTH;
                    held--;
                end
            end
            rrx_pkg::OP_FLUSH:
            begin
                if (xoff_pend)
                begin
                    xoff_pend   = 1'b0;
                    r.send_flow = 1'b1;
                    r.flow_char = rrx_pkg::CHAR_XON;
                end
                wr_ptr = 0;
                rd_ptr = 0;
                held   = 0;
            end
            default: ;
        endcase
        r.fill_count = rrx_pkg::LEVEL_W'(held);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // sender: offers one transaction, holds it until accepted, then
    // records the predicted result; in_valid is left high so a following
    // transaction with no gap never lowers and raises it in one step
    // ------------------------------------------------------------------
    task automatic send_item(input logic [1:0] op_code,
                             input logic [rrx_pkg::DATA_W-1:0] data);
        ring_result_t want;
        // random idle cycles ahead of this transaction
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        op       <= op_code;
        rx_byte  <= data;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // accepted at this edge
        want = ring_next_result(op_code, data);
        pending_results.push_back(want);
        n_items++;
        case (op_code)
            rrx_pkg::OP_RECEIVE: if (!want.overflow) n_stores++;
            rrx_pkg::OP_READ:    if (want.read_valid) n_bytes_out++; else n_empty++;
            rrx_pkg::OP_FLUSH:   n_flushes++;
            default:             n_nops++;
        endcase
        if (want.overflow)
            n_dropped++;
        if (want.send_flow && want.flow_char == rrx_pkg::CHAR_XOFF)
            n_xoff++;
        if (want.send_flow && want.flow_char == rrx_pkg::CHAR_XON)
            n_xon++;
    endtask

    // stop offering and wait until every owed result has been taken
    task automatic wait_ring_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // register write, only called while the block is idle
    task automatic write_reg(input logic [rrx_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rrx_pkg::LEVEL_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            rrx_pkg::CFG_FLOW_ENABLE: flow_on   = value[0];
            rrx_pkg::CFG_HIGH_LEVEL:  high_mark = value;
            rrx_pkg::CFG_LOW_LEVEL:   low_mark  = value;
            default: ;
        endcase
        n_reg_wr++;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // result sink: random stalls, plus long hold-offs on request
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // result checker: every accepted result against the oldest prediction
    // ------------------------------------------------------------------
    task automatic check_field(input string field_name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field_name, want, got);
            err_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        ring_result_t want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transaction with no transaction outstanding");
                err_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("read_valid", 16'(want.read_valid), 16'(read_valid));
                check_field("read_byte",  16'(want.read_byte),  16'(read_byte));
                check_field("send_flow",  16'(want.send_flow),  16'(send_flow));
                check_field("flow_char",  16'(want.flow_char),  16'(flow_char));
                check_field("overflow",   16'(want.overflow),   16'(overflow));
                check_field("fill_count", 16'(want.fill_count), 16'(fill_count));
            end
        end
    end

    // ------------------------------------------------------------------
    // test tasks
    // ------------------------------------------------------------------

    // reset defaults first, then small levels to walk the xoff/xon cycle
    task automatic test_directed();
        // empty read, no-op, byte extremes, in-order return, flush
        send_item(rrx_pkg::OP_READ, 8'h00);
        send_item(OP_NOP, 8'hFF);
        send_item(rrx_pkg::OP_RECEIVE, 8'h00);
        send_item(rrx_pkg::OP_RECEIVE, 8'hFF);
        send_item(rrx_pkg::OP_RECEIVE, 8'hA5);
        send_item(rrx_pkg::OP_RECEIVE, 8'h5A);
        send_item(rrx_pkg::OP_READ, 8'hFF);
        send_item(rrx_pkg::OP_READ, 8'h00);
        send_item(rrx_pkg::OP_FLUSH, 8'h3C);
        send_item(rrx_pkg::OP_READ, 8'hC3);
        wait_ring_idle();

        // flow on via a write with upper junk bits, which must be ignored
        write_reg(rrx_pkg::CFG_FLOW_ENABLE, 13'h1FFF);
        write_reg(rrx_pkg::CFG_HIGH_LEVEL, 13'd2);
        write_reg(rrx_pkg::CFG_LOW_LEVEL, 13'd2);
        write_reg(CFG_UNUSED, 13'h0AAA);
        // third byte crosses the high mark, fourth must not repeat xoff
        send_item(rrx_pkg::OP_RECEIVE, 8'h01);
        send_item(rrx_pkg::OP_RECEIVE, 8'h02);
        send_item(rrx_pkg::OP_RECEIVE, 8'h04);
        send_item(rrx_pkg::OP_RECEIVE, 8'h08);
        // drain until the fill drops under the low mark and xon goes out
        send_item(rrx_pkg::OP_READ, 8'h00);
        send_item(rrx_pkg::OP_READ, 8'h00);
        send_item(rrx_pkg::OP_READ, 8'h00);
        send_item(rrx_pkg::OP_READ, 8'h00);
        send_item(rrx_pkg::OP_READ, 8'h00);
        // xoff again, then a flush releases it
        send_item(rrx_pkg::OP_RECEIVE, 8'h10);
        send_item(rrx_pkg::OP_RECEIVE, 8'h20);
        send_item(rrx_pkg::OP_RECEIVE, 8'h40);
        send_item(rrx_pkg::OP_FLUSH, 8'h80);
        wait_ring_idle();
    endtask

    // level pick: mostly near the fill the random traffic reaches, plus extremes
    function automatic logic [rrx_pkg::LEVEL_W-1:0] pick_level();
        case ($urandom_range(9))
            0:       return '0;
            1:       return rrx_pkg::LEVEL_W'(RING_DEPTH);
            2:       return rrx_pkg::LEVEL_W'($urandom_range(8191));
            default: return rrx_pkg::LEVEL_W'($urandom_range(48));
        endcase
    endfunction

    task automatic random_settings();
        logic [rrx_pkg::LEVEL_W-1:0] flow_word;
        wait_ring_idle();
        flow_word = rrx_pkg::LEVEL_W'($urandom_range(8191));
        if ($urandom_range(3) != 0)
            flow_word[0] = 1'b1;
        write_reg(rrx_pkg::CFG_FLOW_ENABLE, flow_word);
        write_reg(rrx_pkg::CFG_HIGH_LEVEL, pick_level());
        write_reg(rrx_pkg::CFG_LOW_LEVEL, pick_level());
        if ($urandom_range(3) == 0)
            write_reg(CFG_UNUSED, rrx_pkg::LEVEL_W'($urandom_range(8191)));
    endtask

    // bursts of stores and reads so the fill swings across the levels
    task automatic random_traffic(input int count);
        int         sent;
        int         run_len;
        int         kind;
        logic [1:0] pick_op;
        sent = 0;
        while (sent < count)
        begin
            kind    = $urandom_range(99);
            run_len = (kind >= 90) ? 1 : $urandom_range(1, 24);
            for (int k = 0; k < run_len && sent < count; k++)
            begin
                if (kind < 42)
                    pick_op = rrx_pkg::OP_RECEIVE;
                else if (kind < 80)
                    pick_op = rrx_pkg::OP_READ;
                else if (kind < 90)
                    pick_op = $urandom_range(1) ? rrx_pkg::OP_RECEIVE : rrx_pkg::OP_READ;
                else if (kind < 97)
                    pick_op = rrx_pkg::OP_FLUSH;
                else
                    pick_op = OP_NOP;
                send_item(pick_op, rrx_pkg::DATA_W'($urandom_range(255)));
                sent++;
            end
        end
    endtask

    // random traffic in chunks, new register settings between chunks
    task automatic test_random_mix(input int count);
        int left;
        left = count;
        while (left > 0)
        begin
            random_settings();
            random_traffic((left > 100) ? 100 : left);
            left -= 100;
        end
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_backpressure();
        wait_ring_idle();
        write_reg(rrx_pkg::CFG_FLOW_ENABLE, 13'd1);
        write_reg(rrx_pkg::CFG_HIGH_LEVEL, 13'd20);
        write_reg(rrx_pkg::CFG_LOW_LEVEL, 13'd5);
        hold_request = 400;
        for (int k = 0; k < 40; k++)
            send_item(rrx_pkg::OP_RECEIVE, rrx_pkg::DATA_W'($urandom_range(255)));
        for (int k = 0; k < 45; k++)
            send_item(rrx_pkg::OP_READ, rrx_pkg::DATA_W'($urandom_range(255)));
        wait_ring_idle();
    endtask

    // fill the whole ring with wrapped pointers, overflow it, then extreme levels
    task automatic test_full_ring();
        wait_ring_idle();
        write_reg(rrx_pkg::CFG_FLOW_ENABLE, 13'd1);
        write_reg(rrx_pkg::CFG_HIGH_LEVEL, rrx_pkg::LEVEL_W'(RING_DEPTH - 1));
        write_reg(rrx_pkg::CFG_LOW_LEVEL, rrx_pkg::LEVEL_W'(RING_DEPTH));
        send_item(rrx_pkg::OP_FLUSH, 8'h00);
        // move both pointers off zero so the fill wraps the ring
        for (int k = 0; k < 100; k++)
            send_item(rrx_pkg::OP_RECEIVE, rrx_pkg::DATA_W'($urandom_range(255)));
        for (int k = 0; k < 100; k++)
            send_item(rrx_pkg::OP_READ, rrx_pkg::DATA_W'($urandom_range(255)));
        // last store reaches full and raises xoff
        for (int k = 0; k < RING_DEPTH; k++)
            send_item(rrx_pkg::OP_RECEIVE, rrx_pkg::DATA_W'($urandom_range(255)));
        // dropped bytes, no second xoff
        for (int k = 0; k < 3; k++)
            send_item(rrx_pkg::OP_RECEIVE, rrx_pkg::DATA_W'($urandom_range(255)));
        // first read sits at the low mark, the second releases with xon
        for (int k = 0; k < 130; k++)
            send_item(rrx_pkg::OP_READ, rrx_pkg::DATA_W'($urandom_range(255)));
        send_item(rrx_pkg::OP_FLUSH, 8'h00);
        wait_ring_idle();

        // zero levels: any byte raises xoff, no read can release it
        write_reg(rrx_pkg::CFG_HIGH_LEVEL, 13'd0);
        write_reg(rrx_pkg::CFG_LOW_LEVEL, 13'd0);
        send_item(rrx_pkg::OP_RECEIVE, 8'h77);
        send_item(rrx_pkg::OP_READ, 8'h00);
        send_item(rrx_pkg::OP_READ, 8'h00);
        send_item(rrx_pkg::OP_FLUSH, 8'h00);
        wait_ring_idle();
    endtask

    // ------------------------------------------------------------------
    // sequence of the run
    // ------------------------------------------------------------------
    initial
    begin : run_tests
        int waited;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles lightly, receiver stalls heavily
        send_idle_pct  = 30;
        recv_stall_pct = 82;
        test_directed();
        test_random_mix(500);

        // the other way round
        send_idle_pct  = 82;
        recv_stall_pct = 30;
        test_random_mix(500);
        test_backpressure();

        // full rate on both sides
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_full_ring();
        test_random_mix(550);

        // let the last results drain, bounded
        in_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4)
            @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d results never arrived", pending_results.size());
            err_count++;
        end

        $display("covered %0d transactions: %0d stores, %0d bytes read, %0d empty reads,",
                 n_items, n_stores, n_bytes_out, n_empty);
        $display("  %0d flushes, %0d no-ops; flow control: %0d xoff, %0d xon, %0d dropped, %0d reg writes",
                 n_flushes, n_nops, n_xoff, n_xon, n_dropped, n_reg_wr);
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
